### rtl/blvs_pkg.sv
`timescale 1ns / 1ps

package blvs_pkg;

  localparam int NUM_ENTRIES = 1024;
  localparam int ADDR_W      = $clog2(NUM_ENTRIES);
  localparam int STAMP_W     = 32;
  localparam int INDEX_W     = 10;
  localparam int BUCKET_W    = 21;

  typedef logic [1:0]          op_t;
  typedef logic [INDEX_W-1:0]  index_t;
  typedef logic [ADDR_W-1:0]   addr_t;
  typedef logic [STAMP_W-1:0]  stamp_t;
  typedef logic [BUCKET_W-1:0] bucket_t;

  localparam op_t OP_TOUCH = 2'd0;
  localparam op_t OP_INVAL = 2'd1;
  localparam op_t OP_CAND  = 2'd2;

  localparam bucket_t BUCKET_RESET = bucket_t'(1);
  localparam stamp_t  STAMP_MAX    = '1;

endpackage

### rtl/blvs_req_if.sv
`timescale 1ns / 1ps

interface blvs_req_if;
  import blvs_pkg::*;

  logic   valid;
  logic   ready;
  op_t    op;
  index_t entry_index;
  logic   last_candidate;

  modport source (output valid, output op, output entry_index, output last_candidate,
                  input ready);
  modport sink   (input valid, input op, input entry_index, input last_candidate,
                  output ready);
endinterface

### rtl/blvs_rsp_if.sv
`timescale 1ns / 1ps

interface blvs_rsp_if;
  import blvs_pkg::*;

  logic   valid;
  logic   ready;
  index_t victim_index;
  stamp_t victim_stamp;

  modport source (output valid, output victim_index, output victim_stamp, input ready);
  modport sink   (input valid, input victim_index, input victim_stamp, output ready);
endinterface

### rtl/bucketed_lru_victim_select.sv
`timescale 1ns / 1ps

// Bucketed-LRU replacement over a 1024-entry timestamp table held in one
// single-port-write, registered-read RAM. Touches and invalidates write the
// table in the cycle they transfer; a victim candidate reads its stamp and is
// compared against the running minimum in the candidate stage behind the read.
// The block takes one item per cycle outside the clearing pass and stalls; the
// victim of a query is loaded into the result register when its last candidate
// leaves the candidate stage. Only a last candidate that finds the result
// register still full stalls the input. After reset a clearing pass zeroes the
// table, one entry per cycle, and takes no item; bucket_size writes are taken at any time.

module bucketed_lru_victim_select (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  blvs_pkg::bucket_t cfg_wdata,
  blvs_req_if.sink          req,
  blvs_rsp_if.source        rsp
);
  import blvs_pkg::*;

  bucket_t bucket_size;
  bucket_t access_counter;
  bucket_t access_counter_next;
  stamp_t  global_stamp;
  stamp_t  global_stamp_next;

  logic    clearing;
  addr_t   clr_addr;

  logic    s1_valid;
  logic    s1_last;
  index_t  s1_idx;
  stamp_t  rd_stamp;

  logic    query_open;
  index_t  best_index;
  stamp_t  best_stamp;

  logic    s1_adv;
  logic    acc;
  logic    take;
  bucket_t size_eff;
  bucket_t cnt_inc;
  addr_t   slot;

  logic    ram_we;
  addr_t   ram_waddr;
  stamp_t  ram_wdata;
  logic    ram_re;

  assign slot   = req.entry_index[ADDR_W-1:0];
  assign s1_adv = !(s1_valid && s1_last && rsp.valid && !rsp.ready);
  assign req.ready = !clearing && s1_adv;
  assign acc    = req.valid && req.ready;

  // access count and global stamp
  always_comb begin
    size_eff = (bucket_size == '0) ? BUCKET_RESET : bucket_size;
    cnt_inc  = access_counter + BUCKET_RESET;
    if (cnt_inc >= size_eff) begin
      access_counter_next = '0;
      global_stamp_next   = (global_stamp != STAMP_MAX) ? global_stamp + stamp_t'(1)
                                                        : global_stamp;
    end else begin
      access_counter_next = cnt_inc;
      global_stamp_next   = global_stamp;
    end
  end

  always_comb begin
    ram_we    = clearing || (acc && (req.op == OP_TOUCH || req.op == OP_INVAL));
    ram_waddr = clearing ? clr_addr : slot;
    ram_wdata = (!clearing && req.op == OP_TOUCH) ? global_stamp_next : '0;
    ram_re    = acc && (req.op == OP_CAND);
  end

  blvs_ram #(
    .WIDTH (STAMP_W),
    .DEPTH (NUM_ENTRIES)
  ) u_stamps (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (slot),
    .rdata (rd_stamp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + addr_t'(1);
      if (clr_addr == addr_t'(NUM_ENTRIES - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_size <= BUCKET_RESET;
    end else if (cfg_we) begin
      bucket_size <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      access_counter <= '0;
      global_stamp   <= '0;
    end else if (acc && req.op == OP_TOUCH) begin
      access_counter <= access_counter_next;
      global_stamp   <= global_stamp_next;
    end
  end

  // candidate stage, waits on the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_adv) begin
      s1_valid <= ram_re;
    end
  end

  always_ff @(posedge clk) begin
    if (ram_re) begin
      s1_last <= req.last_candidate;
      s1_idx  <= req.entry_index;
    end
  end

  assign take = !query_open || (rd_stamp < best_stamp);

  always_ff @(posedge clk) begin
    if (rst) begin
      query_open <= 1'b0;
    end else if (s1_valid && s1_adv) begin
      query_open <= !s1_last;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_adv && take) begin
      best_index <= s1_idx;
      best_stamp <= rd_stamp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (s1_valid && s1_last && s1_adv) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_last && s1_adv) begin
      rsp.victim_index <= take ? s1_idx : best_index;
      rsp.victim_stamp <= take ? rd_stamp : best_stamp;
    end
  end

  a_no_transfer_while_clearing : assert property (@(posedge clk) disable iff (rst)
    clearing |-> !req.ready)
    else $error("input transfer possible during clearing pass");

  a_stalled_last_holds : assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_last && rsp.valid && !rsp.ready) |=> (s1_valid && s1_last))
    else $error("stalled last candidate lost");

  a_result_from_last : assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(s1_valid && s1_last))
    else $error("result without a last candidate");

  a_stamp_monotonic : assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (global_stamp >= $past(global_stamp)))
    else $error("global stamp went backward");

  a_counter_in_bucket : assert property (@(posedge clk) disable iff (rst)
    (acc && req.op == OP_TOUCH) |=> (access_counter < size_eff || $past(cfg_we)))
    else $error("access count left its bucket");

endmodule

### rtl/blvs_ram.sv
`timescale 1ns / 1ps

module blvs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
